// ----- design/rbd_pkg.sv -----
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int CFG_W           = 12;
  localparam int CFG_IDX_W       = 1;
  localparam int DEF_MAX_WIDTH   = 2048;
  localparam int BYTES_PER_PIXEL = 3;
  localparam int HEIGHT_LIMIT    = 2048;
  localparam int ROW_W           = 11;
  localparam int CH_W            = 2;
  localparam int RESET_WIDTH     = 640;
  localparam int RESET_HEIGHT    = 480;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CH_W-1:0] CH_FIRST = CH_W'(0);
  localparam logic [CH_W-1:0] CH_MID   = CH_W'(1);
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(BYTES_PER_PIXEL - 1);

  typedef logic [2:0] op_t;

  // what the back end does with one pixel byte
  localparam op_t OP_HOLD       = 3'd0;  // even pixel: keep byte for the pair
  localparam op_t OP_STORE_BYTE = 3'd1;  // top row, lone edge byte into line store
  localparam op_t OP_STORE_SUM  = 3'd2;  // top row, pair sum into line store
  localparam op_t OP_EMIT_BYTE  = 3'd3;  // last odd row, lone corner byte
  localparam op_t OP_EMIT_PAIR  = 3'd4;  // last odd row, horizontal pair / 2
  localparam op_t OP_EMIT_VERT  = 3'd5;  // odd right edge, vertical pair / 2
  localparam op_t OP_EMIT_QUAD  = 3'd6;  // full 2x2 block / 4

  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
    logic [7:0]      data;
    logic            done;
  } item_t;

endpackage

// ----- design/rgb_box_downscale_2x2.sv -----
`timescale 1ns / 1ps

// 2x2 box-filter downscaler for 24-bit RGB raster streams.
// Slave stream: one pixel byte per transaction, raster order, three bytes per
// pixel. Master stream: one averaged byte per 2x2 block and channel; tlast
// marks the last byte of the downscaled image. Odd right edges average the
// vertical pair, an odd last row the horizontal pair, a lone corner passes.
// Config port: cfg_index 0 = image_width, 1 = image_height (pixels/rows),
// to be written by the user only while the block is idle, unchecked by the
// block. Out-of-range sizes clamp to 1..max. One byte per clock on both
// sides while m_tready is high, set by the single-port line store, which
// takes one access (top-row write of a sum or lone byte, or read) per byte.
// A front end tracks the raster position and tags each byte, a 4-entry
// queue decouples it from the back end, which owns the line store and the
// output register. When m_tready is low the back end and then the queue
// fill; s_tready drops only once the queue is full. Reset restores 640x480,
// clears position and held bytes; the line store is not cleared (each entry
// is written on a top row before its bottom row reads it).
module rgb_box_downscale_2x2 #(
  parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] pixel_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_byte
  output logic                          m_tlast,   // image_done
  input  logic                          cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]     cfg_data
);
  import rbd_pkg::*;

  localparam int LINE_DEPTH = ((MAX_WIDTH + 1) / 2) * BYTES_PER_PIXEL;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int Q_W        = IDX_W + $bits(item_t);

  logic             push, full, pop, q_valid;
  item_t            f_item, b_item;
  logic [IDX_W-1:0] f_idx, b_idx;
  logic [Q_W-1:0]   q_rdata;

  rbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_ready  (s_tready),
    .q_full    (full),
    .q_push    (push),
    .q_item    (f_item),
    .q_idx     (f_idx)
  );

  rbd_fifo #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_idx, f_item}),
    .full  (full),
    .pop   (pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  assign b_idx  = q_rdata[Q_W-1 -: IDX_W];
  assign b_item = q_rdata[$bits(item_t)-1:0];

  rbd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (b_item),
    .q_idx     (b_idx),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_done  (m_tlast)
  );

endmodule

// ----- design/rbd_front.sv -----
`timescale 1ns / 1ps

module rbd_front #(
  parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
  localparam int LINE_DEPTH = ((MAX_WIDTH + 1) / 2) * rbd_pkg::BYTES_PER_PIXEL,
  localparam int IDX_W = $clog2(LINE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic [7:0]                    in_byte,
  output logic                          in_ready,
  input  logic                          q_full,
  output logic                          q_push,
  output rbd_pkg::item_t                q_item,
  output logic [IDX_W-1:0]              q_idx
);
  import rbd_pkg::*;

  localparam int PIX_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = WEFF_W + 1;
  localparam int ROWC_W = CFG_W + 1;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [WEFF_W-1:0] width_eff;
  logic [CFG_W-1:0]  height_eff;

  logic [PIX_W-1:0]  pix, pix_next;
  logic [CH_W-1:0]   ch, ch_next;
  logic [ROW_W-1:0]  row, row_next;

  logic              col_wrap;
  logic [PIX_W-1:0]  cur_pix;
  logic [CH_W-1:0]   cur_ch;
  logic [ROWC_W-1:0] row_inc;
  logic [ROW_W-1:0]  cur_row;
  logic              pix_last, lone, last_row;
  op_t               op;

  always_comb begin
    if (image_width == '0) begin
      width_eff = WEFF_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      width_eff = WEFF_W'(image_width);
    end
    if (image_height == '0) begin
      height_eff = CFG_W'(1);
    end else if (32'(image_height) > 32'(HEIGHT_LIMIT)) begin
      height_eff = CFG_W'(HEIGHT_LIMIT);
    end else begin
      height_eff = image_height;
    end
  end

  // position of this byte; a shrunk size since the last byte wraps first
  always_comb begin
    col_wrap = CMP_W'(pix) >= CMP_W'(width_eff);
    cur_pix  = col_wrap ? '0 : pix;
    cur_ch   = col_wrap ? CH_FIRST : ch;
    row_inc  = ROWC_W'(row) + ROWC_W'(col_wrap);
    cur_row  = (row_inc >= ROWC_W'(height_eff)) ? '0 : ROW_W'(row_inc);
    pix_last = (CMP_W'(cur_pix) + CMP_W'(1)) >= CMP_W'(width_eff);
    lone     = !cur_pix[0] && pix_last;
    last_row = (ROWC_W'(cur_row) + ROWC_W'(1)) >= ROWC_W'(height_eff);
  end

  always_comb begin
    if (!cur_pix[0] && !lone) begin
      op = OP_HOLD;
    end else if (!cur_row[0]) begin
      if (lone) begin
        op = last_row ? OP_EMIT_BYTE : OP_STORE_BYTE;
      end else begin
        op = last_row ? OP_EMIT_PAIR : OP_STORE_SUM;
      end
    end else begin
      op = lone ? OP_EMIT_VERT : OP_EMIT_QUAD;
    end
  end

  always_comb begin
    pix_next = cur_pix;
    ch_next  = cur_ch;
    row_next = cur_row;
    if (cur_ch == CH_LAST) begin
      ch_next = CH_FIRST;
      if (pix_last) begin
        pix_next = '0;
        row_next = last_row ? '0 : cur_row + ROW_W'(1);
      end else begin
        pix_next = cur_pix + PIX_W'(1);
      end
    end else begin
      ch_next = cur_ch + CH_W'(1);
    end
  end

  assign in_ready    = !q_full;
  assign q_push      = in_valid && !q_full;
  assign q_item.op   = op;
  assign q_item.ch   = cur_ch;
  assign q_item.data = in_byte;
  assign q_item.done = pix_last && (cur_ch == CH_LAST) && last_row;
  assign q_idx       = IDX_W'(32'(cur_pix >> 1) * BYTES_PER_PIXEL + 32'(cur_ch));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(RESET_WIDTH);
      image_height <= CFG_W'(RESET_HEIGHT);
      pix          <= '0;
      ch           <= CH_FIRST;
      row          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (q_push) begin
        pix <= pix_next;
        ch  <= ch_next;
        row <= row_next;
      end
    end
  end

endmodule

// ----- design/rbd_fifo.sv -----
`timescale 1ns / 1ps

module rbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rbd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign valid = count != '0;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/rbd_back.sv -----
`timescale 1ns / 1ps

module rbd_back #(
  parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
  localparam int LINE_DEPTH = ((MAX_WIDTH + 1) / 2) * rbd_pkg::BYTES_PER_PIXEL,
  localparam int IDX_W = $clog2(LINE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rbd_pkg::item_t     q_item,
  input  logic [IDX_W-1:0]   q_idx,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_done
);
  import rbd_pkg::*;

  logic [8:0] line_mem [LINE_DEPTH];
  logic [8:0] rd_sum;
  logic [7:0] held [BYTES_PER_PIXEL];
  logic [7:0] held_sel;
  logic [8:0] pair_sum;
  logic       is_store;

  logic       s1_valid;
  op_t        s1_op;
  logic [7:0] s1_data;
  logic [7:0] s1_held;
  logic       s1_done;
  logic       s1_emit;
  logic [9:0] s1_sum;
  logic [7:0] s1_val;

  logic       out_free, s1_leave, s1_ready;

  always_comb begin
    case (q_item.ch)
      CH_FIRST: held_sel = held[0];
      CH_MID:   held_sel = held[1];
      CH_LAST:  held_sel = held[2];
      default:  held_sel = '0;
    endcase
    pair_sum = {1'b0, held_sel} + {1'b0, q_item.data};
    is_store = (q_item.op == OP_STORE_BYTE) || (q_item.op == OP_STORE_SUM);
  end

  always_comb begin
    s1_emit = 1'b1;
    s1_sum  = '0;
    s1_val  = '0;
    unique case (s1_op) inside
      OP_EMIT_BYTE: s1_val = s1_data;
      OP_EMIT_PAIR: begin
        s1_sum = 10'(s1_held) + 10'(s1_data);
        s1_val = s1_sum[8:1];
      end
      OP_EMIT_VERT: begin
        s1_sum = 10'(rd_sum) + 10'(s1_data);
        s1_val = s1_sum[8:1];
      end
      OP_EMIT_QUAD: begin
        s1_sum = 10'(rd_sum) + 10'(s1_held) + 10'(s1_data);
        s1_val = s1_sum[9:2];
      end
      OP_HOLD, OP_STORE_BYTE, OP_STORE_SUM: s1_emit = 1'b0;
      default: s1_emit = 1'b0;
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign s1_leave = s1_valid && (!s1_emit || out_free);
  assign s1_ready = !s1_valid || s1_leave;
  assign q_pop    = q_valid && s1_ready;

  // single port: a top-row store op (pair sum or lone byte) writes, all else reads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (is_store) begin
        line_mem[q_idx] <= (q_item.op == OP_STORE_SUM) ? pair_sum : {1'b0, q_item.data};
      end else begin
        rd_sum <= line_mem[q_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op   <= q_item.op;
      s1_data <= q_item.data;
      s1_held <= held_sel;
      s1_done <= q_item.done;
    end
    if (out_free && s1_valid && s1_emit) begin
      out_byte <= s1_val;
      out_done <= s1_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
        held[i] <= '0;
      end
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_leave) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= s1_valid && s1_emit;
      end
      if (q_pop && (q_item.op == OP_HOLD)) begin
        case (q_item.ch)
          CH_FIRST: held[0] <= q_item.data;
          CH_MID:   held[1] <= q_item.data;
          CH_LAST:  held[2] <= q_item.data;
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_over_stall: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !(s1_valid && s1_emit && !out_free))
    else $error("queue popped while a result was blocked");

  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_emit))
    else $error("result appeared without an emitting item");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit && !out_free) |=> (s1_valid && $stable(s1_data) && $stable(s1_op)))
    else $error("stalled item lost");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rbd_pkg::*;

  localparam int LINE_DEPTH  = ((DEF_MAX_WIDTH + 1) / 2) * BYTES_PER_PIXEL;
  localparam int RAND_ITEMS  = 1750;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {ROW_CFG, ROW_QUIET, ROW_TYPED, ROW_PREDICT} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      val;
    logic [7:0]            din;
    logic [7:0]            dout;
    logic                  last;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  rgb_box_downscale_2x2 dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the downscaler state
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [8:0]       top_sums [LINE_DEPTH];
  bit               top_written [LINE_DEPTH];
  logic [7:0]       even_bytes [BYTES_PER_PIXEL];
  int unsigned      col_pos;
  int unsigned      row_pos;

  out_beat_t due_bytes [$];
  out_beat_t head;
  int        errors = 0;
  bit        in_idle_on = 1'b1;
  bit        out_idle_on = 1'b1;
  bit        hold_pending = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles;

  stim_row_t dir_table [33] = '{
    // 1x1 image: every byte is a lone corner and passes straight through
    '{ROW_CFG,     REG_IMAGE_WIDTH,  12'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_CFG,     REG_IMAGE_HEIGHT, 12'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'hFF, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'hA5, 8'hA5, 1'b1},
    // 2x1: horizontal pair / 2, last channel sums past 8 bits
    '{ROW_CFG,     REG_IMAGE_WIDTH,  12'd2, 8'h00, 8'h00, 1'b0},
    '{ROW_CFG,     REG_IMAGE_HEIGHT, 12'd1, 8'h00, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'h80, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'h01, 8'h00, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'h80, 8'h80, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'hFF, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'h80, 1'b1},
    // 2x2: full block / 4 at full scale and at zero
    '{ROW_CFG,     REG_IMAGE_HEIGHT, 12'd2, 8'h00, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_QUIET,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'h00, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'hFF, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'h00, 8'h00, 1'b0},
    '{ROW_TYPED,   REG_IMAGE_WIDTH,  12'd0, 8'hFF, 8'hFF, 1'b1},
    // 1x2: odd right edge, vertical pair / 2
    '{ROW_CFG,     REG_IMAGE_WIDTH,  12'd1, 8'h00, 8'h00, 1'b0},
    '{ROW_PREDICT, REG_IMAGE_WIDTH,  12'd0, 8'h10, 8'h00, 1'b0},
    '{ROW_PREDICT, REG_IMAGE_WIDTH,  12'd0, 8'h20, 8'h00, 1'b0},
    '{ROW_PREDICT, REG_IMAGE_WIDTH,  12'd0, 8'h30, 8'h00, 1'b0},
    '{ROW_PREDICT, REG_IMAGE_WIDTH,  12'd0, 8'h30, 8'h00, 1'b0},
    '{ROW_PREDICT, REG_IMAGE_WIDTH,  12'd0, 8'h20, 8'h00, 1'b0},
    '{ROW_PREDICT, REG_IMAGE_WIDTH,  12'd0, 8'h11, 8'h00, 1'b0}
  };

  task automatic mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned cur_width();
    return clamp_dim(width_reg, DEF_MAX_WIDTH);
  endfunction

  function automatic int unsigned cur_height();
    return clamp_dim(height_reg, HEIGHT_LIMIT);
  endfunction

  // one pixel byte through the 2x2 averager; emit is set when it completes a result
  function automatic void downscale_byte(input logic [7:0] b, output bit emit,
                                         output logic [7:0] val, output bit last);
    int unsigned wd, ht, rb, pix, ch, idx, s;
    bit lone, last_row;
    wd = cur_width();
    ht = cur_height();
    rb = wd * BYTES_PER_PIXEL;
    emit = 1'b0;
    val = 8'h00;
    // position may lie outside a freshly shrunk image
    if (col_pos >= rb) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= ht) row_pos = 0;
    pix = col_pos / BYTES_PER_PIXEL;
    ch = col_pos % BYTES_PER_PIXEL;
    idx = (pix >> 1) * BYTES_PER_PIXEL + ch;
    if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
    lone = (pix % 2 == 0) && (pix + 1 >= wd);
    if (row_pos % 2 == 0) begin
      last_row = (row_pos + 1 >= ht);
      if (pix % 2 == 0 && !lone) begin
        even_bytes[ch] = b;
      end else if (lone) begin
        if (last_row) begin
          val = b;
          emit = 1'b1;
        end else begin
          top_sums[idx] = {1'b0, b};
          top_written[idx] = 1'b1;
        end
      end else begin
        s = int'(even_bytes[ch]) + int'(b);
        if (last_row) begin
          val = 8'(s >> 1);
          emit = 1'b1;
        end else begin
          top_sums[idx] = 9'(s);
          top_written[idx] = 1'b1;
        end
      end
    end else begin
      if (pix % 2 == 0 && !lone) begin
        even_bytes[ch] = b;
      end else if (lone) begin
        s = int'(top_sums[idx]) + int'(b);
        val = 8'(s >> 1);
        emit = 1'b1;
      end else begin
        s = int'(top_sums[idx]) + int'(even_bytes[ch]) + int'(b);
        val = 8'(s >> 2);
        emit = 1'b1;
      end
    end
    last = (col_pos + 1 >= rb) && (row_pos + 1 >= ht);
    col_pos++;
    if (col_pos >= rb) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ht) row_pos = 0;
    end
  endfunction

  // A size change must never make a bottom row read a line entry that no
  // top row has written; safe when the new height is one row (no bottom rows),
  // when the next byte opens a top row at column 0, or when every entry the
  // new width uses has been written at some point.
  function automatic bit resize_safe(input logic [CFG_W-1:0] nw, input logic [CFG_W-1:0] nh);
    int unsigned wd, ht, c, r, need;
    wd = clamp_dim(nw, DEF_MAX_WIDTH);
    ht = clamp_dim(nh, HEIGHT_LIMIT);
    if (ht == 1) return 1'b1;
    c = col_pos;
    r = row_pos;
    if (c >= wd * BYTES_PER_PIXEL) begin
      c = 0;
      r++;
    end
    if (r >= ht) r = 0;
    if (r % 2 == 0 && c == 0) return 1'b1;
    need = ((wd + 1) / 2) * BYTES_PER_PIXEL;
    for (int i = 0; i < need; i++) begin
      if (!top_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic void pick_size(output logic [CFG_W-1:0] w, output logic [CFG_W-1:0] h);
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      w = 12'($urandom_range(1, 8));
      h = 12'($urandom_range(1, 6));
    end else if (r < 75) begin
      w = 12'($urandom_range(9, 48));
      h = 12'($urandom_range(1, 4));
    end else if (r < 85) begin
      w = 12'($urandom_range(0, 2));
      h = 12'($urandom_range(0, 3));
    end else if (r < 93) begin
      w = 12'($urandom_range(1, 3));
      case ($urandom_range(3))
        0: h = 12'd2047;
        1: h = 12'd2048;
        2: h = 12'd2049;
        default: h = 12'd4095;
      endcase
    end else begin
      case ($urandom_range(3))
        0: w = 12'd2047;
        1: w = 12'd2048;
        2: w = 12'd2049;
        default: w = 12'd4095;
      endcase
      h = 12'($urandom_range(0, 1));
    end
  endfunction

  // caller sits at a falling edge; returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b, input row_kind_t kind, input out_beat_t typed);
    bit emit, last;
    logic [7:0] val;
    while (in_idle_on && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    downscale_byte(b, emit, val, last);
    if (kind == ROW_TYPED) due_bytes.push_back(typed);
    else if (kind == ROW_PREDICT && emit) due_bytes.push_back(out_beat_t'{val, last});
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (due_bytes.size() != 0) @(negedge clk);
    // bytes that make no result may still be in flight
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sink side: random back-pressure plus an occasional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(out_idle_on && $urandom_range(99) < 36);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_bytes.size() == 0) begin
        mismatch($sformatf("output byte %02h with nothing due", m_tdata));
      end else begin
        head = due_bytes.pop_front();
        if (m_tdata !== head.data)
          mismatch($sformatf("out_byte %02h, want %02h", m_tdata, head.data));
        if (m_tlast !== head.last)
          mismatch($sformatf("image_done %b, want %b", m_tlast, head.last));
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[rgb_box_downscale_2x2] ERROR");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] new_w, new_h, nw, nh;
    int unsigned img, n, sel, phase, rand_bytes;
    bit big;
    width_reg = CFG_W'(RESET_WIDTH);
    height_reg = CFG_W'(RESET_HEIGHT);
    foreach (top_sums[i]) top_sums[i] = '0;
    foreach (even_bytes[i]) even_bytes[i] = '0;
    col_pos = 0;
    row_pos = 0;
    phase = 0;
    rand_bytes = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset size 640x480: the start of the first row is a top row, nothing comes out
    repeat (24) send_byte(rand_byte(), ROW_PREDICT, '0);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) write_reg(dir_table[i].idx, dir_table[i].val);
      else send_byte(dir_table[i].din, dir_table[i].kind,
                     out_beat_t'{dir_table[i].dout, dir_table[i].last});
    end

    while (rand_bytes < RAND_ITEMS) begin
      phase++;
      big = (phase == 4);
      in_idle_on = (phase % 5 != 2);
      out_idle_on = in_idle_on;
      if (big) begin
        new_w = 12'd4095;
        new_h = 12'd1;
        sel = 2;
      end else begin
        pick_size(new_w, new_h);
        sel = (phase == 1) ? 2 : $urandom_range(9);
      end
      nw = (sel == 1) ? width_reg : new_w;
      nh = (sel == 0) ? height_reg : new_h;
      // when the new size could misread the line store, take both new values;
      // if that still could, run out the row at height 1, then set the height
      if (!resize_safe(nw, nh)) begin
        sel = 2;
        if (!resize_safe(new_w, new_h)) begin
          write_reg(REG_IMAGE_WIDTH, new_w);
          write_reg(REG_IMAGE_HEIGHT, 12'd1);
          while (!(col_pos == 0 && row_pos == 0)) begin
            send_byte(rand_byte(), ROW_PREDICT, '0);
            rand_bytes++;
          end
          sel = 1;
        end
      end
      if (sel != 1) write_reg(REG_IMAGE_WIDTH, new_w);
      if (sel != 0) write_reg(REG_IMAGE_HEIGHT, new_h);
      if (phase % 7 == 1) begin
        // sink stalls while the source floods, so the input must back up
        in_idle_on = 1'b0;
        @(posedge clk);
        hold_pending = 1'b1;
        @(negedge clk);
      end
      img = cur_width() * cur_height() * BYTES_PER_PIXEL;
      if (big) begin
        n = $urandom_range(300, 600);
      end else if (img <= 900) begin
        n = img * $urandom_range(1, 2);
        if ($urandom_range(2) == 0) n += $urandom_range(1, img);
      end else begin
        n = $urandom_range(20, 400);
      end
      if (rand_bytes >= RAND_ITEMS) n = 0;
      else if (n > RAND_ITEMS - rand_bytes) n = RAND_ITEMS - rand_bytes;
      repeat (n) send_byte(rand_byte(), ROW_PREDICT, '0);
      rand_bytes += n;
      if ($urandom_range(3) == 0) wait_idle();
    end

    wait_idle();
    if (errors == 0) begin
      $display("[rgb_box_downscale_2x2] OK");
    end else begin
      $display("[rgb_box_downscale_2x2] ERROR");
    end
    $finish;
  end

endmodule
